@@ design/asmc_pkg.sv @@
// ----------------------------------------------------------------------------
// asmc_pkg
// Shared types and constants for the adaptive sliding mode controller.
// ----------------------------------------------------------------------------
package asmc_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic signed [31:0] K1_INIT = 32'sd0;
  // pi rounded to FRAC_BITS fractional bits
  localparam logic signed [32:0] PI_FX     = 33'sd205887;
  localparam logic signed [32:0] TWO_PI_FX = 33'sd411774;

  localparam int SQRT_STEPS = 24;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
  localparam logic [SQRT_CNT_W-1:0] SQRT_LAST = SQRT_CNT_W'(SQRT_STEPS - 1);
  localparam int CFG_W = 31;

  typedef enum logic [2:0] {
    REG_LAMBDA = 3'd0,
    REG_LINEAR = 3'd1,
    REG_FLOOR  = 3'd2,
    REG_ADAPT  = 3'd3,
    REG_BAND   = 3'd4,
    REG_LIMIT  = 3'd5,
    REG_STEP   = 3'd6,
    REG_ANGLE  = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    MUL_LAMBDA_E1 = 2'd0,
    MUL_RATE_DT   = 2'd1,
    MUL_GAIN_ROOT = 2'd2,
    MUL_LIN_S     = 2'd3
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     s_en;
    logic     rate_en;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     gain_en;
    logic     t1_en;
    logic     out_load;
  } asmc_cmd_t;

  typedef struct packed {
    logic sqrt_last;
  } asmc_stat_t;

endpackage

@@ design/adaptive_sliding_mode_controller.sv @@
// ----------------------------------------------------------------------------
// adaptive_sliding_mode_controller
// Second-order adaptive sliding mode controller, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   ref_pos, ref_vel, meas_pos, meas_vel, clamp
// output    out        out_valid_o / out_stall_i drive, surface, adaptive_gain
// config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One item runs from transfer through the sequencer states to the result
// register; the next item is taken in the cycle after. Most of the work is the
// 24-step square root, the rest is one shared 33x33 multiplier used four times.
// Reset clears the gain state and control, presets the config registers; no clearing pass.
// A stalled result holds in the output register; a finished item waits for it.
module adaptive_sliding_mode_controller (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [asmc_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [31:0]         ref_pos_i,
  input  logic signed [31:0]         ref_vel_i,
  input  logic signed [31:0]         meas_pos_i,
  input  logic signed [31:0]         meas_vel_i,
  input  logic                       clamp_output_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [31:0]         drive_o,
  output logic signed [31:0]         surface_o,
  output logic signed [31:0]         adaptive_gain_o
);

  asmc_pkg::asmc_cmd_t  cmd;
  asmc_pkg::asmc_stat_t stat;

  asmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  asmc_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .ref_pos_i       (ref_pos_i),
    .ref_vel_i       (ref_vel_i),
    .meas_pos_i      (meas_pos_i),
    .meas_vel_i      (meas_vel_i),
    .clamp_output_i  (clamp_output_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .drive_o         (drive_o),
    .surface_o       (surface_o),
    .adaptive_gain_o (adaptive_gain_o)
  );

endmodule

@@ design/asmc_datapath.sv @@
// ----------------------------------------------------------------------------
// asmc_datapath
// Registers, shared multiplier and bit-serial square root of the controller.
// ----------------------------------------------------------------------------
module asmc_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [asmc_pkg::CFG_W-1:0] cfg_data_i,
  input  logic signed [31:0]         ref_pos_i,
  input  logic signed [31:0]         ref_vel_i,
  input  logic signed [31:0]         meas_pos_i,
  input  logic signed [31:0]         meas_vel_i,
  input  logic                       clamp_output_i,
  input  asmc_pkg::asmc_cmd_t        cmd_i,
  output asmc_pkg::asmc_stat_t       stat_o,
  output logic signed [31:0]         drive_o,
  output logic signed [31:0]         surface_o,
  output logic signed [31:0]         adaptive_gain_o
);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    begin
      if (v > 64'sh000000007FFFFFFF) r = 32'sh7FFFFFFF;
      else if (v < -64'sh0000000080000000) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction

  function automatic logic signed [31:0] err_calc(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic ang);
    logic signed [32:0] d;
    logic signed [31:0] c;
    logic signed [32:0] e;
    begin
      d = {a[31], a} - {b[31], b};
      c = sat32({{31{d[32]}}, d});
      e = {c[31], c};
      if (ang) begin
        if (e > asmc_pkg::PI_FX) e = e - asmc_pkg::TWO_PI_FX;
        else if (e < -asmc_pkg::PI_FX) e = e + asmc_pkg::TWO_PI_FX;
      end
      return e[31:0];
    end
  endfunction

  logic [30:0] lambda_q, linear_q, floor_q, adapt_q, band_q, limit_q, step_q;
  logic        angle_q;

  logic signed [31:0] e1_q, e2_q, s_q, rate_q, last_q, gain_q;
  logic               clamp_q;
  logic signed [63:0] p_q;
  logic signed [32:0] t1_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  logic [31:0]        mag_s;
  logic [47:0]        x_q;
  logic [26:0]        rem_q;
  logic [23:0]        root_q;
  logic [asmc_pkg::SQRT_CNT_W-1:0] cnt_q;
  logic [26:0]        rem_sh, trial;
  logic signed [31:0] t1_sat, t2_sat, u_sat, u_clamp;
  logic signed [32:0] lim_s;
  logic signed [31:0] drive_q, surf_q, again_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q <= 31'd65536;
      linear_q <= 31'd65536;
      floor_q  <= 31'd6554;
      adapt_q  <= 31'd65536;
      band_q   <= 31'd6554;
      limit_q  <= 31'd655360;
      step_q   <= 31'd655;
      angle_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (asmc_pkg::reg_idx_e'(cfg_idx_i))
        asmc_pkg::REG_LAMBDA: lambda_q <= cfg_data_i;
        asmc_pkg::REG_LINEAR: linear_q <= cfg_data_i;
        asmc_pkg::REG_FLOOR:  floor_q  <= cfg_data_i;
        asmc_pkg::REG_ADAPT:  adapt_q  <= cfg_data_i;
        asmc_pkg::REG_BAND:   band_q   <= cfg_data_i;
        asmc_pkg::REG_LIMIT:  limit_q  <= cfg_data_i;
        asmc_pkg::REG_STEP:   step_q   <= cfg_data_i;
        asmc_pkg::REG_ANGLE:  angle_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      asmc_pkg::MUL_LAMBDA_E1: begin
        mul_a = {2'b00, lambda_q};
        mul_b = {e1_q[31], e1_q};
      end
      asmc_pkg::MUL_RATE_DT: begin
        mul_a = {rate_q[31], rate_q} + {last_q[31], last_q};
        mul_b = {2'b00, step_q};
      end
      asmc_pkg::MUL_GAIN_ROOT: begin
        mul_a = {gain_q[31], gain_q};
        mul_b = {9'd0, root_q};
      end
      asmc_pkg::MUL_LIN_S: begin
        mul_a = {2'b00, linear_q};
        mul_b = {s_q[31], s_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign mag_s    = s_q[31] ? 32'(-s_q) : 32'(s_q);

  // one root bit per step, two radicand bits brought down
  assign rem_sh = {rem_q[24:0], x_q[47:46]};
  assign trial  = {1'b0, root_q, 2'b01};

  assign t1_sat  = sat32(p_q >>> asmc_pkg::FRAC_BITS);
  assign t2_sat  = sat32(p_q >>> asmc_pkg::FRAC_BITS);
  assign u_sat   = sat32({{31{t1_q[32]}}, t1_q} + {{32{t2_sat[31]}}, t2_sat});
  assign lim_s   = {2'b00, limit_q};

  always_comb begin
    u_clamp = u_sat;
    if (clamp_q) begin
      if ($signed({u_sat[31], u_sat}) > lim_s) u_clamp = lim_s[31:0];
      else if ($signed({u_sat[31], u_sat}) < -lim_s) u_clamp = 32'(-lim_s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= asmc_pkg::K1_INIT;
      last_q <= '0;
    end else if (cmd_i.gain_en) begin
      gain_q <= sat32($signed({{32{gain_q[31]}}, gain_q}) +
                      (p_q >>> (asmc_pkg::FRAC_BITS + 1)));
      last_q <= rate_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      e1_q    <= err_calc(ref_pos_i, meas_pos_i, angle_q);
      e2_q    <= err_calc(ref_vel_i, meas_vel_i, angle_q);
      clamp_q <= clamp_output_i;
    end
    if (cmd_i.mul_en) p_q <= mul_full[63:0];
    if (cmd_i.s_en)
      s_q <= sat32($signed({{32{e2_q[31]}}, e2_q}) + (p_q >>> asmc_pkg::FRAC_BITS));
    if (cmd_i.rate_en) begin
      if ($signed({gain_q[31], gain_q}) > $signed({2'b00, floor_q})) begin
        if (mag_s > {1'b0, band_q}) rate_q <= {1'b0, adapt_q};
        else if (mag_s < {1'b0, band_q}) rate_q <= 32'(-{1'b0, adapt_q});
        else rate_q <= '0;
      end else begin
        rate_q <= {1'b0, floor_q};
      end
    end
    if (cmd_i.sqrt_init) begin
      x_q    <= {mag_s, 16'd0};
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.sqrt_step) begin
      x_q   <= {x_q[45:0], 2'b00};
      cnt_q <= cnt_q + 1'b1;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[22:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[22:0], 1'b0};
      end
    end
    if (cmd_i.t1_en)
      t1_q <= s_q[31] ? -{t1_sat[31], t1_sat} : {t1_sat[31], t1_sat};
    if (cmd_i.out_load) begin
      drive_q <= u_clamp;
      surf_q  <= s_q;
      again_q <= gain_q;
    end
  end

  assign stat_o.sqrt_last = (cnt_q == asmc_pkg::SQRT_LAST);
  assign drive_o          = drive_q;
  assign surface_o        = surf_q;
  assign adaptive_gain_o  = again_q;

endmodule

@@ design/asmc_ctrl.sv @@
// ----------------------------------------------------------------------------
// asmc_ctrl
// Sequencer for one control step and the result valid flag.
// ----------------------------------------------------------------------------
module asmc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  asmc_pkg::asmc_stat_t stat_i,
  output asmc_pkg::asmc_cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_MUL_S   = 10'b0000000010,
    ST_CALC_S  = 10'b0000000100,
    ST_RATE    = 10'b0000001000,
    ST_MUL_DT  = 10'b0000010000,
    ST_GAIN    = 10'b0000100000,
    ST_SQRT    = 10'b0001000000,
    ST_MUL_T1  = 10'b0010000000,
    ST_MUL_T2  = 10'b0100000000,
    ST_FINISH  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   oval_q, oval_d;
  logic   out_free;

  assign out_free   = !oval_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    oval_d  = oval_q && out_stall_i;
    cmd_o   = '0;
    cmd_o.mul_sel = asmc_pkg::MUL_LAMBDA_E1;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL_S;
        end
      end
      ST_MUL_S: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_CALC_S;
      end
      ST_CALC_S: begin
        cmd_o.s_en = 1'b1;
        state_d    = ST_RATE;
      end
      ST_RATE: begin
        cmd_o.rate_en   = 1'b1;
        cmd_o.sqrt_init = 1'b1;
        state_d         = ST_MUL_DT;
      end
      ST_MUL_DT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = asmc_pkg::MUL_RATE_DT;
        state_d       = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.gain_en = 1'b1;
        state_d       = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (stat_i.sqrt_last) state_d = ST_MUL_T1;
      end
      ST_MUL_T1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = asmc_pkg::MUL_GAIN_ROOT;
        state_d       = ST_MUL_T2;
      end
      ST_MUL_T2: begin
        // t1 taken from the gain product while the linear term is formed
        cmd_o.t1_en   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = asmc_pkg::MUL_LIN_S;
        state_d       = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          oval_d         = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end

  assign out_valid_o = oval_q;

endmodule

@@ design/asmc_checker.sv @@
// ----------------------------------------------------------------------------
// asmc_sva
// Port-level checks of the controller's handshakes.
// ----------------------------------------------------------------------------
module asmc_sva (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  // a pending result is not dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one item at a time: busy right after a transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transfer");

  // no result appears the cycle right after an input transfer
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result too early");

  // a new result comes only from a busy block
  a_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work");

endmodule

bind adaptive_sliding_mode_controller asmc_sva u_asmc_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

@@ sim/asmc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmc_checker
// Watches the input and output channels of the sliding mode controller, runs
// a fixed-point model of the control law on every input transfer and compares
// each output transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module asmc_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [asmc_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic signed [31:0]         ref_pos_i,
  input  logic signed [31:0]         ref_vel_i,
  input  logic signed [31:0]         meas_pos_i,
  input  logic signed [31:0]         meas_vel_i,
  input  logic                       clamp_output_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic signed [31:0]         drive_i,
  input  logic signed [31:0]         surface_i,
  input  logic signed [31:0]         adaptive_gain_i,
  output int                         errors_o,
  output int                         pending_o
);

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] surface;
    logic signed [31:0] gain;
  } ctrl_out_t;

  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;

  ctrl_out_t expected_q[$];
  logic signed [63:0] lambda_r, linear_r, floor_r, adapt_r, band_r, limit_r, step_r;
  logic               angle_r;
  logic signed [63:0] k1, prev_rate;

  function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
    if (v > MAX32) return MAX32;
    if (v < MIN32) return MIN32;
    return v;
  endfunction

  // arithmetic shift of a signed value floors toward minus infinity
  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> asmc_pkg::FRAC_BITS;
  endfunction

  function automatic logic signed [63:0] wrap_pi(input logic signed [63:0] e);
    logic signed [63:0] pi_v;
    pi_v = asmc_pkg::PI_FX;
    if (e > pi_v) return e - 2 * pi_v;
    if (e < -pi_v) return e + 2 * pi_v;
    return e;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic predict_control(input logic signed [31:0] rp, rv, mp, mv,
                                 input logic clamp);
    logic signed [63:0] e1, e2, s, mag, diff, rate, delta, root, t1, t2, u;
    ctrl_out_t res;
    e1 = clip32(64'(rp) - 64'(mp));
    e2 = clip32(64'(rv) - 64'(mv));
    if (angle_r) begin
      e1 = wrap_pi(e1);
      e2 = wrap_pi(e2);
    end
    s = clip32(e2 + qmul(lambda_r, e1));
    mag = (s < 0) ? -s : s;
    if (k1 > floor_r) begin
      diff = mag - band_r;
      rate = (diff > 0) ? adapt_r : ((diff < 0) ? -adapt_r : 64'sd0);
    end else begin
      rate = floor_r;
    end
    delta = ((rate + prev_rate) * step_r) >>> (asmc_pkg::FRAC_BITS + 1);
    k1 = clip32(k1 + delta);
    prev_rate = rate;
    root = $signed(int_sqrt(64'(mag) << asmc_pkg::FRAC_BITS));
    t1 = clip32(qmul(k1, root));
    if (s < 0) t1 = -t1;
    t2 = clip32(qmul(linear_r, s));
    u = clip32(t1 + t2);
    if (clamp) begin
      if (u > limit_r) u = limit_r;
      else if (u < -limit_r) u = -limit_r;
    end
    res.drive = u[31:0];
    res.surface = s[31:0];
    res.gain = k1[31:0];
    expected_q.push_back(res);
  endtask

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    ctrl_out_t exp_r;
    if (!rst_ni) begin
      lambda_r <= 65536;
      linear_r <= 65536;
      floor_r <= 6554;
      adapt_r <= 65536;
      band_r <= 6554;
      limit_r <= 655360;
      step_r <= 655;
      angle_r <= 1'b0;
      k1 = 64'(asmc_pkg::K1_INIT);
      prev_rate = 0;
      errors_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (asmc_pkg::reg_idx_e'(cfg_idx_i))
          asmc_pkg::REG_LAMBDA: lambda_r <= 64'(cfg_data_i);
          asmc_pkg::REG_LINEAR: linear_r <= 64'(cfg_data_i);
          asmc_pkg::REG_FLOOR:  floor_r  <= 64'(cfg_data_i);
          asmc_pkg::REG_ADAPT:  adapt_r  <= 64'(cfg_data_i);
          asmc_pkg::REG_BAND:   band_r   <= 64'(cfg_data_i);
          asmc_pkg::REG_LIMIT:  limit_r  <= 64'(cfg_data_i);
          asmc_pkg::REG_STEP:   step_r   <= 64'(cfg_data_i);
          asmc_pkg::REG_ANGLE:  angle_r  <= cfg_data_i[0];
          default: ;
        endcase
      end
      // k1 and prev_rate update in place, so each prediction sees the last one
      if (in_valid_i && !in_stall_i)
        predict_control(ref_pos_i, ref_vel_i, meas_pos_i, meas_vel_i, clamp_output_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transfer drive=%0d surface=%0d gain=%0d", $time,
                   drive_i, surface_i, adaptive_gain_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.drive !== drive_i || exp_r.surface !== surface_i ||
              exp_r.gain !== adaptive_gain_i) begin
            $display("%0t: expected drive=%0d surface=%0d gain=%0d, got %0d %0d %0d",
                     $time, exp_r.drive, exp_r.surface, exp_r.gain,
                     drive_i, surface_i, adaptive_gain_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

@@ sim/adaptive_sliding_mode_controller_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_sliding_mode_controller_tb
// Drives directed and random control samples through several register
// settings with random gaps and output stalls; the checker gives the verdict.
// ----------------------------------------------------------------------------
module adaptive_sliding_mode_controller_tb;

  localparam int MAX_CYCLES = 400000;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [asmc_pkg::CFG_W-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic signed [31:0] ref_pos_i, ref_vel_i, meas_pos_i, meas_vel_i;
  logic clamp_output_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] drive_o, surface_o, adaptive_gain_o;
  int errors, pending;
  int cycles = 0;
  logic calm;  // no idling on either side

  adaptive_sliding_mode_controller i_dut (.*);

  asmc_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o),
    .ref_pos_i, .ref_vel_i, .meas_pos_i, .meas_vel_i, .clamp_output_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .drive_i(drive_o), .surface_i(surface_o), .adaptive_gain_i(adaptive_gain_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("adaptive_sliding_mode_controller: mismatch");
      $finish;
    end
  end

  always @(negedge clk_i)
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 19);

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $signed($urandom_range(400000)) - 200000;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic write_reg(input asmc_pkg::reg_idx_e idx,
                           input logic [asmc_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send(input logic signed [31:0] rp, rv, mp, mv, input logic cl);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    ref_pos_i <= rp;
    ref_vel_i <= rv;
    meas_pos_i <= mp;
    meas_vel_i <= mv;
    clamp_output_i <= cl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++)
      send(rand_val(), rand_val(), rand_val(), rand_val(), 1'($urandom_range(1)));
    drain();
  endtask

  initial begin
    calm = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = asmc_pkg::REG_LAMBDA;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    ref_pos_i = '0;
    ref_vel_i = '0;
    meas_pos_i = '0;
    meas_vel_i = '0;
    clamp_output_i = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, surface exactly on band, clamp both ways
    send(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1'b0);
    send(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b1);
    send(0, 0, 0, 0, 1'b0);
    send(0, 6554, 0, 0, 1'b0);
    send(0, -6554, 0, 0, 1'b1);
    send(0, 6554, 0, 0, 1'b1);
    send(32'sh00100000, 0, 0, 0, 1'b1);
    send(-32'sh00100000, 0, 0, 0, 1'b1);
    send(-1, -1, 0, 0, 1'b0);
    drain();
    write_reg(asmc_pkg::REG_ANGLE, 31'd1);
    // angular fold: just over pi each way, exactly pi, and saturated errors
    send(205888, 205888, 0, 0, 1'b0);
    send(-205888, -205888, 0, 0, 1'b0);
    send(205887, -205887, 0, 0, 1'b0);
    send(32'sh7fffffff, 32'sh80000000, -1, 1, 1'b1);
    send(32'sh80000000, 32'sh7fffffff, 1, -1, 1'b1);
    random_phase(150);

    write_reg(asmc_pkg::REG_ANGLE, 31'd0);
    write_reg(asmc_pkg::REG_LAMBDA, '1);
    write_reg(asmc_pkg::REG_LINEAR, '1);
    write_reg(asmc_pkg::REG_FLOOR, '1);
    write_reg(asmc_pkg::REG_ADAPT, '1);
    write_reg(asmc_pkg::REG_BAND, '1);
    write_reg(asmc_pkg::REG_LIMIT, '1);
    write_reg(asmc_pkg::REG_STEP, '1);
    random_phase(150);

    // zero lambda, linear, floor, band and limit
    write_reg(asmc_pkg::REG_LAMBDA, 31'd0);
    write_reg(asmc_pkg::REG_LINEAR, 31'd0);
    write_reg(asmc_pkg::REG_FLOOR, 31'd0);
    write_reg(asmc_pkg::REG_BAND, 31'd0);
    write_reg(asmc_pkg::REG_LIMIT, 31'd0);
    random_phase(150);

    write_reg(asmc_pkg::REG_LAMBDA, 31'd131072);
    write_reg(asmc_pkg::REG_LINEAR, 31'd32768);
    write_reg(asmc_pkg::REG_FLOOR, 31'd100);
    write_reg(asmc_pkg::REG_ADAPT, 31'd3000000);
    write_reg(asmc_pkg::REG_BAND, 31'd50000);
    write_reg(asmc_pkg::REG_LIMIT, 31'd300000);
    write_reg(asmc_pkg::REG_STEP, 31'd65536);
    calm = 1'b1;
    random_phase(200);
    calm = 1'b0;

    for (int k = 0; k < 4; k++) begin
      for (int r = 0; r < 7; r++)
        write_reg(asmc_pkg::reg_idx_e'(r),
                  asmc_pkg::CFG_W'($urandom_range(3) == 0 ? $urandom()
                                                          : $urandom_range(200000)));
      write_reg(asmc_pkg::REG_ANGLE, asmc_pkg::CFG_W'($urandom_range(1)));
      random_phase(100);
    end

    if (errors == 0 && pending == 0) begin
      $display("adaptive_sliding_mode_controller: match");
    end else begin
      $display("adaptive_sliding_mode_controller: mismatch");
    end
    $finish;
  end
endmodule

@@ adaptive_sliding_mode_controller.f @@
design/asmc_pkg.sv
design/asmc_datapath.sv
design/asmc_ctrl.sv
design/adaptive_sliding_mode_controller.sv
design/asmc_checker.sv
sim/asmc_checker.sv
sim/adaptive_sliding_mode_controller_tb.sv
